>>> src/ffgt_pkg.sv
// Shared types and codes for the first-fit gap table.
package ffgt_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIND  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_GAP  = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_FIT  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN2_RD,
    S_SCAN2_CHK,
    S_APPLY,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN_START,
    CMD_SCAN_RD,
    CMD_SCAN_STEP,
    CMD_APPLY,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR
  } cmd_e;

  // Datapath status back to controller
  typedef struct packed {
    logic scan_end;   // index reached gap_count
    logic hit;        // scan stopped on a matching entry
    logic chk_hit;    // entry just read matches
    logic need_shift; // apply removed a gap
    logic shift_end;  // shift finished
  } dp_status_t;

endpackage

>>> src/ffgt_ctrl.sv
// Controller FSM sequencing scans, updates and entry shifts.
module ffgt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [1:0]          op_i,
  input  ffgt_pkg::dp_status_t st_i,
  input  logic                out_free_i,
  output ffgt_pkg::cmd_e      cmd_o,
  output logic                second_o,
  output logic                busy_o,
  output logic                done_o
);
  import ffgt_pkg::*;

  state_e state_q, state_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    unique case (state_q)
      S_IDLE: if (in_fire_i) begin
        second_d = 1'b0;
        state_d  = (op_i == OP_NOP) ? S_APPLY : S_SCAN_RD;
      end
      S_SCAN_RD:  state_d = st_i.scan_end ? S_APPLY : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (st_i.chk_hit) state_d = S_APPLY;
        else state_d = S_SCAN_RD;
      end
      S_SCAN2_RD:  state_d = st_i.scan_end ? S_APPLY : S_SCAN2_CHK;
      S_SCAN2_CHK: state_d = st_i.chk_hit ? S_APPLY : S_SCAN2_RD;
      S_APPLY: begin
        // free misses the offset: search again with offset+size
        if (op_i == OP_FREE && !second_q && !st_i.hit) begin
          second_d = 1'b1;
          state_d  = S_SCAN2_RD;
        end else if (st_i.need_shift) state_d = S_SHIFT_RD;
        else state_d = S_DONE;
      end
      S_SHIFT_RD: state_d = st_i.shift_end ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_DONE:     if (out_free_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = CMD_NONE;
    unique case (state_q)
      S_IDLE:      if (in_fire_i) cmd_o = CMD_LOAD;
      S_SCAN_RD, S_SCAN2_RD: cmd_o = CMD_SCAN_RD;
      S_SCAN_CHK, S_SCAN2_CHK: cmd_o = CMD_SCAN_STEP;
      S_APPLY: begin
        if (op_i == OP_FREE && !second_q && !st_i.hit) cmd_o = CMD_SCAN_START;
        else cmd_o = CMD_APPLY;
      end
      S_SHIFT_RD:  cmd_o = CMD_SHIFT_RD;
      S_SHIFT_WR:  cmd_o = CMD_SHIFT_WR;
      default:     cmd_o = CMD_NONE;
    endcase
  end

  assign second_o = second_q;
  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_DONE) && out_free_i;
endmodule

>>> src/ffgt_dp.sv
// Datapath: gap memory, scan index, extent and result formation.
module ffgt_dp #(
  parameter int MaxGaps = 16,
  parameter int IdxW    = 4,
  parameter int CntW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffgt_pkg::cmd_e      cmd_i,
  input  logic                second_i,
  input  logic [1:0]          op_i,
  input  logic [30:0]         off_i,
  input  logic [30:0]         size_i,
  output ffgt_pkg::dp_status_t st_o,
  output logic [1:0]          status_o,
  output logic [31:0]         found_o,
  output logic [31:0]         extent_o
);
  import ffgt_pkg::*;

  logic [63:0] mem [MaxGaps];
  logic [31:0] rs_q, re_q;
  logic [CntW-1:0] idx_q, cnt_q;
  logic [31:0] ext_q, found_q;
  logic [1:0]  status_q;
  logic [1:0]  op_q;
  logic [31:0] off_q, size_q, top_q;
  logic        hit_q;
  logic        split_pend_q;

  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [63:0] wr_data;
  logic [IdxW-1:0] rd_addr;
  logic        hit_c;
  logic [31:0] key;

  assign key = second_i ? top_q : off_q;
  always_comb begin
    if (op_q == OP_FIND)
      hit_c = (re_q >= rs_q) && ((re_q - rs_q) >= size_q);
    else
      hit_c = (key >= rs_q) && (key < re_q);
  end

  assign rd_addr = (cmd_i == CMD_SHIFT_RD) ? IdxW'(idx_q + CntW'(1)) : idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i == CMD_SCAN_RD || cmd_i == CMD_SHIFT_RD) begin
      rs_q <= mem[rd_addr][31:0];
      re_q <= mem[rd_addr][63:32];
    end
  end

  // memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[IdxW-1:0];
    wr_data = {re_q, rs_q};
    if (split_pend_q) begin
      // upper part of a split goes to the tail slot claimed at apply
      wr_en = 1'b1; wr_addr = IdxW'(cnt_q - CntW'(1)); wr_data = {re_q, top_q};
    end else if (cmd_i == CMD_SHIFT_WR) begin
      wr_en = 1'b1;
    end else if (cmd_i == CMD_APPLY) begin
      unique case (op_q)
        OP_ALLOC: if (hit_q) begin
          if (off_q == rs_q) begin
            if (top_q != re_q) begin
              wr_en = 1'b1; wr_data = {re_q, top_q};
            end
          end else begin
            wr_en = !(top_q != re_q && cnt_q >= CntW'(MaxGaps));
            wr_data = {off_q, rs_q};
          end
        end
        OP_FREE: begin
          if (hit_q) begin
            wr_en = 1'b1;
            wr_data = second_i ? {re_q, off_q} : {top_q, rs_q};
          end else if (cnt_q < CntW'(MaxGaps)) begin
            wr_en = 1'b1; wr_addr = cnt_q[IdxW-1:0]; wr_data = {top_q, off_q};
          end
        end
        default: ;
      endcase
    end
  end

  logic split_fire;
  assign split_fire = (cmd_i == CMD_APPLY) && op_q == OP_ALLOC && hit_q
                      && off_q != rs_q && top_q != re_q && cnt_q < CntW'(MaxGaps);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; cnt_q <= '0; ext_q <= '0; hit_q <= 1'b0;
      status_q <= ST_OK; found_q <= '0; split_pend_q <= 1'b0; op_q <= OP_NOP;
      off_q <= '0; size_q <= '0; top_q <= '0;
    end else begin
      split_pend_q <= 1'b0;
      unique case (cmd_i)
        CMD_LOAD: begin
          op_q <= op_i; off_q <= {1'b0, off_i}; size_q <= {1'b0, size_i};
          top_q <= {1'b0, off_i} + {1'b0, size_i};
          idx_q <= '0; hit_q <= 1'b0;
        end
        CMD_SCAN_START: begin idx_q <= '0; hit_q <= 1'b0; end
        CMD_SCAN_RD: ;
        // stay on a matching entry, else move on
        CMD_SCAN_STEP: begin
          if (hit_c) hit_q <= 1'b1;
          else idx_q <= idx_q + CntW'(1);
        end
        CMD_SHIFT_RD: ;
        CMD_SHIFT_WR: idx_q <= idx_q + CntW'(1);
        CMD_APPLY: begin
          status_q <= ST_OK; found_q <= '0;
          unique case (op_q)
            OP_ALLOC: begin
              if (!hit_q) status_q <= ST_NO_GAP;
              else if (off_q != rs_q && top_q != re_q && cnt_q >= CntW'(MaxGaps))
                status_q <= ST_FULL;
              else begin
                if (top_q > ext_q) ext_q <= top_q;
                if (off_q == rs_q && top_q == re_q) begin
                  cnt_q <= cnt_q - CntW'(1);
                end
                if (split_fire) begin
                  split_pend_q <= 1'b1;
                  cnt_q <= cnt_q + CntW'(1);
                end
              end
            end
            OP_FREE: begin
              if (!hit_q && cnt_q >= CntW'(MaxGaps)) status_q <= ST_FULL;
              else begin
                if (top_q == ext_q) ext_q <= off_q;
                if (!hit_q) cnt_q <= cnt_q + CntW'(1);
              end
            end
            OP_FIND: begin
              if (hit_q) found_q <= rs_q;
              else status_q <= ST_NO_FIT;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign st_o.scan_end   = (idx_q >= cnt_q) || (idx_q >= CntW'(MaxGaps));
  assign st_o.hit        = hit_q;
  assign st_o.chk_hit    = hit_c;
  assign st_o.need_shift = (op_q == OP_ALLOC) && hit_q && off_q == rs_q && top_q == re_q;
  // after the delete, cnt_q already decremented: copy while idx < cnt
  assign st_o.shift_end  = (idx_q >= cnt_q);

  assign status_o = status_q;
  assign found_o  = found_q;
  assign extent_o = ext_q;
endmodule

>>> src/first_fit_gap_table_core.sv
// Top level of the first-fit gap table.
// Keeps up to MAX_GAPS free intervals [start,end) and a running extent.
// Input channel s_axis: one operation per transfer (allocate, free, find or no-op).
// Output channel m_axis: one result per operation with status, found start
// and the extent after the operation.
// Each allocate, free or find scans the table entry by entry (registered
// memory read, then compare), stopping at the first match or after the last
// gap; a free that misses the offset scans again with offset+size.
// An allocate that deletes a gap then moves the later entries down by one.
// s_axis_tready rises when the result is loaded into the output register.
// One operation is in flight at a time; s_axis_tready is low while busy.
// The result is held in the output register until the receiver takes it;
// a stalled receiver holds the block in its done state.
// Reset empties the table and clears the extent; entries are not cleared,
// only the gap count.
module first_fit_gap_table_core #(
  parameter int MAX_GAPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [32:2] chunk_offset, [63:33] chunk_size
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] found_start, [65:34] current_extent, zero fill
  output logic [71:0] m_axis_tdata
);
  import ffgt_pkg::*;

  localparam int IdxW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
  localparam int CntW = $clog2(MAX_GAPS + 1);

  cmd_e        cmd;
  dp_status_t  st;
  logic        second, busy, done;
  logic        in_fire;
  logic [1:0]  op_q;
  logic [1:0]  status;
  logic [31:0] found, ext;
  logic        ov_q;
  logic [65:0] od_q;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_q <= OP_NOP;
    else if (in_fire) op_q <= s_axis_tdata[1:0];
  end

  ffgt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire),
    .op_i(busy ? op_q : s_axis_tdata[1:0]), .st_i(st),
    .out_free_i(!ov_q || m_axis_tready), .cmd_o(cmd), .second_o(second),
    .busy_o(busy), .done_o(done)
  );

  ffgt_dp #(.MaxGaps(MAX_GAPS), .IdxW(IdxW), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .second_i(second),
    .op_i(s_axis_tdata[1:0]), .off_i(s_axis_tdata[32:2]),
    .size_i(s_axis_tdata[63:33]), .st_o(st), .status_o(status),
    .found_o(found), .extent_o(ext)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) od_q <= {ext, found, status};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, od_q};
endmodule

>>> tb/sv/tb_first_fit_gap_table_core.sv
// Self-checking testbench for the first-fit gap table core.
module tb_first_fit_gap_table_core;
  import ffgt_pkg::*;

  localparam int NGAPS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  // lowest field last, matching the result tdata layout
  typedef struct packed {
    logic [31:0] extent;
    logic [31:0] found_start;
    status_e     status;
  } gap_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  // predictor state
  logic [31:0] gs [NGAPS];
  logic [31:0] ge [NGAPS];
  int          gcount;
  logic [31:0] gextent;

  gap_result_t expected_results[$];
  int          fail_count;
  int          cycle_count;
  int          hold_off;  // forced long receiver stall when nonzero
  bit          rx_random;

  first_fit_gap_table_core #(.MAX_GAPS(NGAPS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  function automatic int find_holder(input logic [31:0] x);
    for (int i = 0; i < gcount; i++)
      if (x >= gs[i] && x < ge[i]) return i;
    return gcount;
  endfunction

  function automatic gap_result_t predict_gap_op(input op_e op, input logic [30:0] off31,
                                                 input logic [30:0] size31);
    gap_result_t r;
    logic [31:0] off, sz, top;
    int p;
    off = {1'b0, off31};
    sz = {1'b0, size31};
    top = off + sz;
    r.status = ST_OK;
    r.found_start = '0;
    case (op)
      OP_ALLOC: begin
        p = find_holder(off);
        if (p >= gcount) r.status = ST_NO_GAP;
        else begin
          if (off == gs[p]) begin
            if (top == ge[p]) begin
              for (int i = p; i + 1 < gcount; i++) begin
                gs[i] = gs[i+1];
                ge[i] = ge[i+1];
              end
              gcount--;
            end else gs[p] = top;
          end else if (top == ge[p]) ge[p] = off;
          else if (gcount >= NGAPS) r.status = ST_FULL;
          else begin
            gs[gcount] = top;
            ge[gcount] = ge[p];
            gcount++;
            ge[p] = off;
          end
          if (r.status == ST_OK && top > gextent) gextent = top;
        end
      end
      OP_FREE: begin
        p = find_holder(off);
        if (p < gcount) ge[p] = top;
        else begin
          p = find_holder(top);
          if (p < gcount) gs[p] = off;
          else if (gcount >= NGAPS) r.status = ST_FULL;
          else begin
            gs[gcount] = off;
            ge[gcount] = top;
            gcount++;
          end
        end
        if (r.status == ST_OK && top == gextent) gextent = off;
      end
      OP_FIND: begin
        r.status = ST_NO_FIT;
        for (int i = 0; i < gcount; i++)
          if (ge[i] >= gs[i] && ge[i] - gs[i] >= sz) begin
            r.status = ST_OK;
            r.found_start = gs[i];
            break;
          end
      end
      default: ;
    endcase
    r.extent = gextent;
    return r;
  endfunction

  // tvalid stays up into the next call when that call does not idle
  task automatic send_op(input op_e op, input logic [30:0] off, input logic [30:0] sz);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sz, off, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_gap_op(op, off, sz));
    @(negedge clk_i);
  endtask

  // receiver ready drive
  initial begin
    int w;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else if (!rx_random) m_axis_tready <= 1'b1;
      else if (m_axis_tready && !m_axis_tvalid) ;
      else begin
        w = $urandom_range(0, 19);
        if (w > 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    gap_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[65:0];
      if (expected_results.size() == 0)
        report("unexpected result", 32'(got.status), 32'd0);
      else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.found_start != want.found_start)
          report("found_start", got.found_start, want.found_start);
        if (got.extent != want.extent) report("extent", got.extent, want.extent);
      end
    end
  end

  // random offset biased to lie near existing gap boundaries
  function automatic logic [30:0] near_gap();
    int p;
    if (gcount == 0 || $urandom_range(0, 9) == 0) return 31'($urandom_range(0, 300));
    p = $urandom_range(0, gcount - 1);
    case ($urandom_range(0, 3))
      0: return gs[p][30:0];
      1: return 31'(ge[p][30:0] - 31'($urandom_range(1, 8)));
      2: return 31'(gs[p][30:0] + 31'($urandom_range(0, 8)));
      default: return ge[p][30:0];
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_FIND, 0, 0);                  // empty table, no fit
    send_op(OP_ALLOC, 5, 5);                 // no gap
    send_op(OP_FREE, 100, 50);               // append [100,150)
    send_op(OP_FIND, 31'h7fffffff, 0);       // zero size fits
    send_op(OP_ALLOC, 100, 10);              // trim start
    send_op(OP_ALLOC, 140, 10);              // trim end
    send_op(OP_ALLOC, 120, 5);               // split
    send_op(OP_FIND, 0, 10);
    send_op(OP_FREE, 110, 2);                // shrink end
    send_op(OP_FREE, 120, 5);                // extend start of holder of top
    send_op(OP_ALLOC, 125, 30);              // past end: inverted gap
    send_op(OP_FIND, 0, 31'h7fffffff);       // no fit
    send_op(OP_FREE, 31'h7fffffff, 31'h7fffffff); // extremes
    send_op(OP_ALLOC, 31'h7fffffff, 31'h7fffffff);
    send_op(OP_NOP, 31'h7fffffff, 31'h7fffffff);
    for (int i = 0; i < 18; i++) send_op(OP_FREE, 31'(1000 + 10 * i), 5); // fill up
    send_op(OP_ALLOC, 1001, 1);              // split with full table
    send_op(OP_FIND, 0, 5);
  endtask

  task automatic test_random(input int n);
    op_e op;
    logic [30:0] off, sz;
    for (int i = 0; i < n; i++) begin
      op = op_e'($urandom_range(0, 12) == 0 ? 3 : $urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) begin
        off = 31'($urandom());
        sz = 31'($urandom());
      end else begin
        off = near_gap();
        sz = 31'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(0, 40));
      end
      // keep the table from saturating forever
      if (gcount >= NGAPS - 1 && op == OP_FREE && $urandom_range(0, 1)) op = OP_ALLOC;
      send_op(op, off, sz);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 6; i++) send_op(OP_FIND, 0, 31'($urandom_range(0, 20)));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    cycle_count = 0;
    hold_off = 0;
    rx_random = 1'b0;
    gcount = 0;
    gextent = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    rx_random = 1'b1;
    test_random(800);
    test_backpressure();
    test_random(800);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/ffgt_pkg.sv
src/ffgt_ctrl.sv
src/ffgt_dp.sv
src/first_fit_gap_table_core.sv
tb/sv/tb_first_fit_gap_table_core.sv
